// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer cache package
// Types and constants shared by the buffer cache cell row and its controller.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned DefEntries = 32;
  localparam int unsigned IdxMaxW    = 8;
  localparam logic [7:0]  CountMax   = 8'hFF;

  typedef logic [IdxMaxW-1:0] idx_t;

  typedef enum logic [1:0] {
    CmdGet     = 2'd0,
    CmdRelease = 2'd1,
    CmdPin     = 2'd2,
    CmdUnpin   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoFree = 2'd1,
    StUnder  = 2'd2,
    StSat    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  device_id;
    logic [19:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic valid;
    idx_t idx;
  } commit_t;

  // search token passed down the cell row
  typedef struct packed {
    logic        valid;
    logic        hit;
    idx_t        hit_idx;
    logic        fill;
    logic        found;
    idx_t        best_idx;
    logic [31:0] best_time;
    status_e     status;
  } token_t;

endpackage

// ===== rtl/block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// LRU buffer cache tag table
// Row of entry cells searched by a token that moves one cell per cycle, with
// a controller that issues transactions, retags a victim and holds results.
//
//   Channel   Handshake                 Payload
//   in        in_valid_i / in_ready_o   cmd, device_id, block_number,
//                                       entry_index, now
//   out       out_valid_o / out_ready_i status, slot, was_hit, needs_fill
//
// A result is offered once the token has walked the cell row, one entry per
// cycle, and the result has passed through res_q into the output register;
// the next transaction is accepted once the controller is back in SIdle.
// One transaction is in flight; a new one is taken while a result waits.
// A result that finds the output register full waits until it is taken.
// Reset clears all entries at once; no sweep is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_buffer_cache_lru #(
  parameter int unsigned ENTRIES = bbc_pkg::DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  device_id_i,
  input  logic [19:0] block_number_i,
  input  logic [4:0]  entry_index_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  slot_o,
  output logic        was_hit_o,
  output logic        needs_fill_o
);

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SDeliver
  } state_e;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic       hit;
    logic       fill;
  } result_t;

  state_e           state_q;
  bbc_pkg::req_t    req_q;
  bbc_pkg::commit_t commit_q, commit_d;
  logic             start_q;
  result_t          res_q, res_d, out_q;
  logic             out_valid_q;

  bbc_pkg::token_t  tok [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vld;
  bbc_pkg::token_t  last;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = start_q;
    tok[0].status = bbc_pkg::StOk;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bbc_cell #(
      .Index (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req_q),
      .commit_i (commit_q),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  assign last = tok[ENTRIES];

  always_comb begin
    res_d    = '0;
    commit_d = '0;
    if (req_q.cmd == bbc_pkg::CmdGet) begin
      if (last.hit) begin
        res_d.status = last.status;
        res_d.slot   = 5'(last.hit_idx);
        res_d.hit    = 1'b1;
        res_d.fill   = last.fill;
      end else if (last.found) begin
        res_d.status    = bbc_pkg::StOk;
        res_d.slot      = 5'(last.best_idx);
        res_d.fill      = 1'b1;
        commit_d.valid  = 1'b1;
        commit_d.idx    = last.best_idx;
      end else begin
        res_d.status = bbc_pkg::StNoFree;
      end
    end else begin
      res_d.status = last.status;
      res_d.slot   = req_q.entry_index;
    end
  end

  assign in_ready_o = (state_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      start_q     <= 1'b0;
      commit_q    <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      start_q  <= (state_q == SIdle) && in_valid_i;
      commit_q <= ((state_q == SScan) && last.valid) ? commit_d : '0;
      if ((state_q == SDeliver) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            req_q.cmd          <= bbc_pkg::cmd_e'(cmd_i);
            req_q.device_id    <= device_id_i;
            req_q.block_number <= block_number_i;
            req_q.entry_index  <= entry_index_i;
            req_q.now          <= now_i;
            state_q            <= SScan;
          end
        end
        SScan: begin
          if (last.valid) begin
            res_q   <= res_d;
            state_q <= SDeliver;
          end
        end
        SDeliver: begin
          if (!out_valid_q || out_ready_i) begin
            out_q   <= res_q;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign slot_o       = out_q.slot;
  assign was_hit_o    = out_q.hit;
  assign needs_fill_o = out_q.fill;

  `ASSERT_PROP(a_one_token, clk_i, rst_ni, $onehot0(tok_vld), "more than one token in the row")
  `ASSERT_NEXT(a_inject, clk_i, rst_ni, in_valid_i && in_ready_o, tok[0].valid, "token not injected")
  `ASSERT_PROP(a_exit_scan, clk_i, rst_ni, !last.valid || state_q == SScan, "token left row outside scan")
  `ASSERT_PROP(a_commit_idle_row, clk_i, rst_ni, !(commit_q.valid && (|tok_vld || start_q)), "retag during a search")
  `ASSERT_PROP(a_load_deliver, clk_i, rst_ni, !$rose(out_valid_o) || $past(state_q == SDeliver), "result without delivery")

endmodule

// ===== rtl/bbc_cell.sv =====
// ----------------------------------------------------------------------------
// Buffer cache cell
// One cache entry: tags, valid flag, reference count and last-use time. It
// updates the search token from its own entry and hands it to the next cell.
// ----------------------------------------------------------------------------
module bbc_cell #(
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbc_pkg::req_t    req_i,
  input  bbc_pkg::commit_t commit_i,
  input  bbc_pkg::token_t  tok_i,
  output bbc_pkg::token_t  tok_o
);

  logic [7:0]      dev_q, dev_d;
  logic [19:0]     blk_q, blk_d;
  logic            vld_q, vld_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [31:0]     use_q, use_d;
  bbc_pkg::token_t tok_q, tok_d;

  logic is_get, tag_hit, take_hit, take_free, addressed, committed;

  always_comb begin
    dev_d = dev_q;
    blk_d = blk_q;
    vld_d = vld_q;
    cnt_d = cnt_q;
    use_d = use_q;
    tok_d = tok_i;

    is_get    = (req_i.cmd == bbc_pkg::CmdGet);
    tag_hit   = (dev_q == req_i.device_id) && (blk_q == req_i.block_number);
    take_hit  = tok_i.valid && is_get && !tok_i.hit && tag_hit;
    take_free = tok_i.valid && is_get && (cnt_q == 8'd0) &&
                (!tok_i.found || (use_q < tok_i.best_time));
    addressed = tok_i.valid && !is_get &&
                (bbc_pkg::idx_t'(req_i.entry_index) == bbc_pkg::idx_t'(Index));
    committed = commit_i.valid && (commit_i.idx == bbc_pkg::idx_t'(Index));

    if (committed) begin
      dev_d = req_i.device_id;
      blk_d = req_i.block_number;
      cnt_d = 8'd1;
      use_d = req_i.now;
      vld_d = 1'b1;
    end

    if (take_hit) begin
      if (cnt_q == bbc_pkg::CountMax) begin
        tok_d.status = bbc_pkg::StSat;
      end else begin
        cnt_d = cnt_q + 8'd1;
      end
      use_d         = req_i.now;
      vld_d         = 1'b1;
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = bbc_pkg::idx_t'(Index);
      tok_d.fill    = !vld_q;
    end

    if (take_free) begin
      tok_d.found     = 1'b1;
      tok_d.best_idx  = bbc_pkg::idx_t'(Index);
      tok_d.best_time = use_q;
    end

    if (addressed) begin
      if (req_i.cmd == bbc_pkg::CmdPin) begin
        if (cnt_q == bbc_pkg::CountMax) begin
          tok_d.status = bbc_pkg::StSat;
        end else begin
          cnt_d = cnt_q + 8'd1;
        end
      end else if (cnt_q == 8'd0) begin
        tok_d.status = bbc_pkg::StUnder;
      end else begin
        cnt_d = cnt_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
      blk_q <= '0;
      vld_q <= 1'b0;
      cnt_q <= '0;
      use_q <= '0;
      tok_q <= '0;
    end else begin
      dev_q <= dev_d;
      blk_q <= blk_d;
      vld_q <= vld_d;
      cnt_q <= cnt_d;
      use_q <= use_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
